FILE: rtl/pdr_pkg.sv
// Constants and register indexes shared by the pointer delta rotator.
`default_nettype none

package pdr_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int AXIS_COUNT = 2;

  localparam int VALUE_W = 32;
  localparam int COEF_W = 16;
  localparam int CODE_W = 16;
  localparam int TYPE_W = 8;
  localparam int TICK_W = 8;
  localparam int PROD_W = VALUE_W + COEF_W;
  localparam int SUM_W = PROD_W + 1;

  typedef enum logic [2:0] {
    REG_ROTATE_ENABLE = 3'd0,
    REG_COS_COEF      = 3'd1,
    REG_SIN_COEF      = 3'd2,
    REG_EVENT_TYPE    = 3'd3,
    REG_CODE_X        = 3'd4,
    REG_CODE_Y        = 3'd5,
    REG_CODE_COUNT    = 3'd6,
    REG_TIMEOUT_TICKS = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/pointer_delta_rotator.sv
// Pointer delta rotator: accumulates x/y deltas, rotates each pair when it is
// complete or its timeout runs out, and passes each non-tick event on.
// Beats pass stages 1 to 3, then the result register; one input beat per cycle
//   unless stalled; the single result register drains 0 to 3 results per item.
// Four 32x16 multipliers run in parallel in the second stage.
// Reset: synchronous; config returns to defaults, sums, flags and timer clear.
`default_nettype none

module pointer_delta_rotator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  pdr_pkg::reg_idx_t      cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [7:0]             ev_type,
  input  logic [15:0]            ev_code,
  input  logic signed [31:0]     ev_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [15:0]            out_code,
  output logic signed [31:0]     out_value,
  output logic                   sync,
  output logic                   last
);
  import pdr_pkg::*;

  localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((64'sd1 <<< COEF_FRAC_BITS) - 64'sd1);
  localparam logic signed [SUM_W-1:0] QMAX = SUM_W'(64'sh7fffffff);
  localparam logic signed [SUM_W-1:0] QMIN = -QMAX - SUM_W'(1);
  localparam logic [1:0] AXES_MAX = 2'(AXIS_COUNT);

  // configuration
  logic                      rotate_enable;
  logic signed [COEF_W-1:0]  cos_coef;
  logic signed [COEF_W-1:0]  sin_coef;
  logic [TYPE_W-1:0]         event_type;
  logic [CODE_W-1:0]         code_x;
  logic [CODE_W-1:0]         code_y;
  logic [1:0]                code_count;
  logic [TICK_W-1:0]         timeout_ticks;

  // accumulation state
  logic signed [VALUE_W-1:0] pending_x, pending_x_next;
  logic signed [VALUE_W-1:0] pending_y, pending_y_next;
  logic                      has_x, has_x_next;
  logic                      has_y, has_y_next;
  logic [TICK_W-1:0]         timer_left, timer_left_next;
  logic                      timer_armed, timer_armed_next;

  // stage 1
  logic                      s1_valid;
  logic                      s1_flush;
  logic signed [VALUE_W-1:0] s1_x, s1_y;
  logic                      s1_pass;
  logic [CODE_W-1:0]         s1_code;
  logic signed [VALUE_W-1:0] s1_value;

  // stage 2
  logic                      s2_valid;
  logic                      s2_flush;
  logic signed [PROD_W-1:0]  s2_xc, s2_ys, s2_xs, s2_yc;
  logic                      s2_pass;
  logic [CODE_W-1:0]         s2_code;
  logic signed [VALUE_W-1:0] s2_value;

  // stage 3
  logic                      s3_valid;
  logic                      s3_flush;
  logic signed [SUM_W-1:0]   s3_sx, s3_sy;
  logic                      s3_pass;
  logic [CODE_W-1:0]         s3_code;
  logic signed [VALUE_W-1:0] s3_value;

  // result register
  logic                      g_x, g_y, g_p;
  logic signed [VALUE_W-1:0] g_rx, g_ry;
  logic                      g_sync_x;
  logic [CODE_W-1:0]         g_code;
  logic signed [VALUE_W-1:0] g_value;

  logic accept, out_take, free, ld1, ld2, ld3;

  // front-end combinational signals
  logic [1:0]                axes_n;
  logic                      hit, axis_x, axis_y;
  logic signed [VALUE_W:0]   acc_sum;
  logic signed [VALUE_W-1:0] acc_sat;
  logic                      do_flush, all_in;
  logic signed [VALUE_W-1:0] fx, fy;

  // back-end combinational signals
  logic signed [SUM_W-1:0]   qx, qy;
  logic signed [VALUE_W-1:0] rx, ry;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_enable <= 1'b0;
      cos_coef      <= COEF_W'(16384);
      sin_coef      <= '0;
      event_type    <= TYPE_W'(2);
      code_x        <= '0;
      code_y        <= CODE_W'(1);
      code_count    <= 2'd2;
      timeout_ticks <= TICK_W'(10);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATE_ENABLE: rotate_enable <= cfg_data[0];
        REG_COS_COEF:      cos_coef      <= cfg_data[COEF_W-1:0];
        REG_SIN_COEF:      sin_coef      <= cfg_data[COEF_W-1:0];
        REG_EVENT_TYPE:    event_type    <= cfg_data[TYPE_W-1:0];
        REG_CODE_X:        code_x        <= cfg_data[CODE_W-1:0];
        REG_CODE_Y:        code_y        <= cfg_data[CODE_W-1:0];
        REG_CODE_COUNT:    code_count    <= cfg_data[1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake and pipeline advance
  assign out_valid = g_x | g_y | g_p;
  assign out_take  = out_valid & ~out_stall;
  assign free      = ~out_valid | (out_take & last);
  assign ld3       = ~s3_valid | free;
  assign ld2       = ~s2_valid | ld3;
  assign ld1       = ~s1_valid | ld2;
  assign in_stall  = ~ld1;
  assign accept    = in_valid & ~in_stall;

  // match, accumulate, timer
  always_comb begin
    axes_n = (code_count > AXES_MAX) ? AXES_MAX : code_count;
    hit    = rotate_enable & (ev_type == event_type) & ~func;
    axis_x = hit & (axes_n >= 2'd1) & (ev_code == code_x);
    axis_y = hit & ~axis_x & (axes_n >= 2'd2) & (ev_code == code_y);

    acc_sum = (axis_x ? (VALUE_W+1)'(pending_x) : (VALUE_W+1)'(pending_y))
              + (VALUE_W+1)'(ev_value);
    if (acc_sum[VALUE_W] != acc_sum[VALUE_W-1]) begin
      acc_sat = acc_sum[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[VALUE_W-1:0];
    end

    pending_x_next   = pending_x;
    pending_y_next   = pending_y;
    has_x_next       = has_x;
    has_y_next       = has_y;
    timer_left_next  = timer_left;
    timer_armed_next = timer_armed;
    do_flush         = 1'b0;
    all_in           = 1'b0;

    if (accept) begin
      if (func) begin
        if (timer_armed) begin
          if (timer_left <= TICK_W'(1)) begin
            do_flush         = 1'b1;
            timer_armed_next = 1'b0;
            timer_left_next  = '0;
          end else begin
            timer_left_next = timer_left - TICK_W'(1);
          end
        end
      end else if (axis_x | axis_y) begin
        if (axis_x) begin
          pending_x_next = acc_sat;
          has_x_next     = 1'b1;
        end else begin
          pending_y_next = acc_sat;
          has_y_next     = 1'b1;
        end
        all_in = has_x_next & ((axes_n < 2'd2) | has_y_next);
        if (all_in) begin
          do_flush         = 1'b1;
          timer_armed_next = 1'b0;
          timer_left_next  = '0;
        end else begin
          timer_armed_next = 1'b1;
          timer_left_next  = timeout_ticks;
        end
      end
    end

    fx = has_x_next ? pending_x_next : '0;
    fy = has_y_next ? pending_y_next : '0;
    if (do_flush) begin
      pending_x_next = '0;
      pending_y_next = '0;
      has_x_next     = 1'b0;
      has_y_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_x   <= '0;
      pending_y   <= '0;
      has_x       <= 1'b0;
      has_y       <= 1'b0;
      timer_left  <= '0;
      timer_armed <= 1'b0;
    end else begin
      pending_x   <= pending_x_next;
      pending_y   <= pending_y_next;
      has_x       <= has_x_next;
      has_y       <= has_y_next;
      timer_left  <= timer_left_next;
      timer_armed <= timer_armed_next;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (ld1) begin
        s1_valid <= accept;
      end
      if (ld2) begin
        s2_valid <= s1_valid;
      end
      if (ld3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_flush <= do_flush;
      s1_x     <= fx;
      s1_y     <= fy;
      s1_pass  <= ~func;
      s1_code  <= ev_code;
      s1_value <= (axis_x | axis_y) ? '0 : ev_value;
    end
    if (ld2) begin
      s2_flush <= s1_flush;
      s2_xc    <= PROD_W'(s1_x) * PROD_W'(cos_coef);
      s2_ys    <= PROD_W'(s1_y) * PROD_W'(sin_coef);
      s2_xs    <= PROD_W'(s1_x) * PROD_W'(sin_coef);
      s2_yc    <= PROD_W'(s1_y) * PROD_W'(cos_coef);
      s2_pass  <= s1_pass;
      s2_code  <= s1_code;
      s2_value <= s1_value;
    end
    if (ld3) begin
      s3_flush <= s2_flush;
      s3_sx    <= SUM_W'(s2_xc) - SUM_W'(s2_ys);
      s3_sy    <= SUM_W'(s2_xs) + SUM_W'(s2_yc);
      s3_pass  <= s2_pass;
      s3_code  <= s2_code;
      s3_value <= s2_value;
    end
  end

  // truncate toward zero, saturate
  always_comb begin
    qx = (s3_sx + (s3_sx[SUM_W-1] ? FRAC_MASK : SUM_W'(0))) >>> COEF_FRAC_BITS;
    qy = (s3_sy + (s3_sy[SUM_W-1] ? FRAC_MASK : SUM_W'(0))) >>> COEF_FRAC_BITS;
    if (qx > QMAX) begin
      rx = VALUE_W'(QMAX);
    end else if (qx < QMIN) begin
      rx = VALUE_W'(QMIN);
    end else begin
      rx = VALUE_W'(qx);
    end
    if (qy > QMAX) begin
      ry = VALUE_W'(QMAX);
    end else if (qy < QMIN) begin
      ry = VALUE_W'(QMIN);
    end else begin
      ry = VALUE_W'(qy);
    end
  end

  // result register: load a new group or drop the beat just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      g_x <= 1'b0;
      g_y <= 1'b0;
      g_p <= 1'b0;
    end else if (free) begin
      g_x <= s3_valid & s3_flush & (rx != '0);
      g_y <= s3_valid & s3_flush & (ry != '0);
      g_p <= s3_valid & s3_pass;
    end else if (out_take) begin
      if (g_x) begin
        g_x <= 1'b0;
      end else if (g_y) begin
        g_y <= 1'b0;
      end else begin
        g_p <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      g_rx     <= rx;
      g_ry     <= ry;
      g_sync_x <= (ry == '0);
      g_code   <= s3_code;
      g_value  <= s3_value;
    end
  end

  always_comb begin
    if (g_x) begin
      kind      = 1'b1;
      out_code  = code_x;
      out_value = g_rx;
      sync      = g_sync_x;
      last      = ~(g_y | g_p);
    end else if (g_y) begin
      kind      = 1'b1;
      out_code  = code_y;
      out_value = g_ry;
      sync      = 1'b1;
      last      = ~g_p;
    end else begin
      kind      = 1'b0;
      out_code  = g_code;
      out_value = g_value;
      sync      = 1'b0;
      last      = 1'b1;
    end
  end

  a_armed_has_pending: assert property (@(posedge clk) disable iff (rst)
    timer_armed |-> (has_x | has_y))
    else $error("timer armed with no pending axis");

  a_disarmed_clear: assert property (@(posedge clk) disable iff (rst)
    !timer_armed |-> (timer_left == '0))
    else $error("timer count left over while disarmed");

  a_stage1_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with first stage empty");

  a_pass_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !kind) |-> last)
    else $error("passed-on beat not last of its item");

endmodule

`default_nettype wire
